>>> hw/rtl/bnms_pkg.sv
package bnms_pkg;

  localparam int DEF_MAX_BOXES  = 64;
  localparam int DEF_COORD_BITS = 12;
  localparam int SCORE_BITS     = 16;
  localparam int CFG_IDX_BITS   = 1;
  localparam int CFG_DATA_BITS  = 8;

  localparam logic [CFG_IDX_BITS-1:0]  REG_OVERLAP   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0]  REG_IOU       = 1'b1;
  localparam logic [CFG_DATA_BITS-1:0] OVERLAP_RESET = 8'd128;
  localparam logic [CFG_DATA_BITS-1:0] IOU_RESET     = 8'd51;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_I,
    RD_J,
    RD_K
  } rd_sel_t;

  typedef struct packed {
    logic    load_new;
    logic    count_inc;
    logic    count_clr;
    logic    p_load;
    logic    p_dec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_new;
    logic    wr_shift;
    logic    i_clr;
    logic    i_inc;
    logic    j_load;
    logic    j_dec;
    logic    bi_load;
    logic    kill_j;
    logic    kill_i;
    logic    k_clr;
    logic    k_inc;
    logic    pend_load;
    logic    pend_clr;
    logic    out_load;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic p_zero;
    logic area_ge;
    logic i_done;
    logic j_gt_i;
    logic alive;
    logic contain;
    logic iou_hit;
    logic score_ge;
    logic k_done;
    logic pend_valid;
    logic out_busy;
  } status_t;

endpackage

>>> hw/rtl/bnms_ctrl.sv
module bnms_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last_in,
  output logic             in_ready,
  output bnms_pkg::cmd_t   cmd,
  input  bnms_pkg::status_t sts
);
  import bnms_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    INS_CHK,
    INS_CMP,
    SUP_IFIND,
    SUP_ICHK,
    SUP_JCHK,
    SUP_JWAIT,
    SUP_M1,
    SUP_M2,
    SUP_M3,
    SUP_DEC,
    EMIT_CHK,
    EMIT_TEST,
    EMIT_LAST
  } state_t;

  state_t state, state_next;
  logic   last_set, last_set_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    cmd           = '0;
    cmd.rd_sel    = RD_PREV;
    state_next    = state;
    last_set_next = last_set;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load_new  = 1'b1;
          cmd.p_load    = 1'b1;
          last_set_next = last_in;
          if (!sts.full) begin
            state_next = INS_CHK;
          end else if (last_in) begin
            cmd.i_clr  = 1'b1;
            state_next = SUP_IFIND;
          end
        end
      end
      INS_CHK: begin
        if (sts.p_zero) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.i_clr     = 1'b1;
          state_next    = last_set ? SUP_IFIND : IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_PREV;
          state_next = INS_CMP;
        end
      end
      INS_CMP: begin
        if (sts.area_ge) begin
          cmd.wr_new    = 1'b1;
          cmd.count_inc = 1'b1;
          cmd.i_clr     = 1'b1;
          state_next    = last_set ? SUP_IFIND : IDLE;
        end else begin
          cmd.wr_shift = 1'b1;
          cmd.p_dec    = 1'b1;
          state_next   = INS_CHK;
        end
      end
      SUP_IFIND: begin
        if (sts.i_done) begin
          cmd.k_clr    = 1'b1;
          cmd.pend_clr = 1'b1;
          state_next   = EMIT_CHK;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_I;
          state_next = SUP_ICHK;
        end
      end
      SUP_ICHK: begin
        if (sts.alive) begin
          cmd.bi_load = 1'b1;
          cmd.j_load  = 1'b1;
          state_next  = SUP_JCHK;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = SUP_IFIND;
        end
      end
      SUP_JCHK: begin
        if (sts.j_gt_i) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_J;
          state_next = SUP_JWAIT;
        end else begin
          cmd.i_inc  = 1'b1;
          state_next = SUP_IFIND;
        end
      end
      SUP_JWAIT: begin
        if (sts.alive) begin
          state_next = SUP_M1;
        end else begin
          cmd.j_dec  = 1'b1;
          state_next = SUP_JCHK;
        end
      end
      SUP_M1: state_next = SUP_M2;
      SUP_M2: state_next = SUP_M3;
      SUP_M3: state_next = SUP_DEC;
      SUP_DEC: begin
        if (sts.contain || (sts.iou_hit && sts.score_ge)) begin
          cmd.kill_j = 1'b1;
          cmd.j_dec  = 1'b1;
          state_next = SUP_JCHK;
        end else if (sts.iou_hit) begin
          // drop i and restart the scan at the next position
          cmd.kill_i = 1'b1;
          cmd.i_inc  = 1'b1;
          state_next = SUP_IFIND;
        end else begin
          cmd.j_dec  = 1'b1;
          state_next = SUP_JCHK;
        end
      end
      EMIT_CHK: begin
        if (sts.k_done) begin
          state_next = EMIT_LAST;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_K;
          state_next = EMIT_TEST;
        end
      end
      EMIT_TEST: begin
        if (!sts.alive) begin
          cmd.k_inc  = 1'b1;
          state_next = EMIT_CHK;
        end else if (!sts.pend_valid) begin
          cmd.pend_load = 1'b1;
          cmd.k_inc     = 1'b1;
          state_next    = EMIT_CHK;
        end else if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.pend_load = 1'b1;
          cmd.k_inc     = 1'b1;
          state_next    = EMIT_CHK;
        end
      end
      EMIT_LAST: begin
        if (!sts.pend_valid) begin
          cmd.count_clr = 1'b1;
          state_next    = IDLE;
        end else if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_last  = 1'b1;
          cmd.count_clr = 1'b1;
          state_next    = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      last_set <= 1'b0;
    end else begin
      state    <= state_next;
      last_set <= last_set_next;
    end
  end

endmodule

>>> hw/rtl/bnms_dp.sv
module bnms_dp #(
  parameter int MAX_BOXES  = bnms_pkg::DEF_MAX_BOXES,
  parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bnms_pkg::cmd_t                     cmd,
  output bnms_pkg::status_t                  sts,
  input  logic                               cfg_en,
  input  logic [bnms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bnms_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic [COORD_BITS-1:0]              box_x,
  input  logic [COORD_BITS-1:0]              box_y,
  input  logic [COORD_BITS-1:0]              box_w,
  input  logic [COORD_BITS-1:0]              box_h,
  input  logic [bnms_pkg::SCORE_BITS-1:0]    score,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COORD_BITS-1:0]              out_x,
  output logic [COORD_BITS-1:0]              out_y,
  output logic [COORD_BITS-1:0]              out_w,
  output logic [COORD_BITS-1:0]              out_h,
  output logic [bnms_pkg::SCORE_BITS-1:0]    out_score,
  output logic                               last_out
);
  import bnms_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int AW     = $clog2(MAX_BOXES);
  localparam int CW     = $clog2(MAX_BOXES + 1);
  localparam int AB     = 2 * C;
  localparam int EW     = 4 * C + SCORE_BITS + AB;
  localparam int S_LO   = AB;
  localparam int H_LO   = AB + SCORE_BITS;
  localparam int W_LO   = H_LO + C;
  localparam int Y_LO   = W_LO + C;
  localparam int X_LO   = Y_LO + C;

  logic [CFG_DATA_BITS-1:0] ov_q8, iou_q8;

  logic [EW-1:0] mem [MAX_BOXES];
  logic          alive_mem [MAX_BOXES];
  logic [EW-1:0] q;
  logic          alive_q;

  logic [CW-1:0] count, p, i, k;
  logic [AW-1:0] j;
  logic [AW-1:0] rd_addr, alive_waddr;
  logic          alive_we, alive_wdata;

  logic [C-1:0]          nb_x, nb_y, nb_w, nb_h;
  logic [SCORE_BITS-1:0] nb_s;
  logic [AB-1:0]         nb_area;
  logic [EW-1:0]         bi, pend;
  logic                  pend_valid;

  logic [C-1:0]          qx, qy, qw, qh, bx, by, bw, bh;
  logic [SCORE_BITS-1:0] qs, bs;
  logic [AB-1:0]         qa, ba;
  logic [C:0]            ax2, bx2, ay2, by2, x1, y1, x2, y2;
  logic [C:0]            dx, dy;
  logic [AB+1:0]         inter;
  logic [AB+7:0]         prod1;
  logic [AB:0]           un;
  logic [AB+8:0]         prod2;
  logic                  contain;

  assign {qx, qy, qw, qh, qs, qa} = q;
  assign {bx, by, bw, bh, bs, ba} = bi;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV: rd_addr = AW'(p - 1'b1);
      RD_I:    rd_addr = i[AW-1:0];
      RD_J:    rd_addr = j;
      RD_K:    rd_addr = k[AW-1:0];
      default: rd_addr = j;
    endcase
  end

  always_comb begin
    alive_we    = cmd.wr_new | cmd.wr_shift | cmd.kill_j | cmd.kill_i;
    alive_wdata = cmd.wr_new | cmd.wr_shift;
    if (cmd.kill_j) begin
      alive_waddr = j;
    end else if (cmd.kill_i) begin
      alive_waddr = i[AW-1:0];
    end else begin
      alive_waddr = p[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_new) begin
      mem[p[AW-1:0]] <= {nb_x, nb_y, nb_w, nb_h, nb_s, nb_area};
    end else if (cmd.wr_shift) begin
      mem[p[AW-1:0]] <= q;
    end
    if (alive_we) begin
      alive_mem[alive_waddr] <= alive_wdata;
    end
    if (cmd.rd_en) begin
      q       <= mem[rd_addr];
      alive_q <= alive_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov_q8  <= OVERLAP_RESET;
      iou_q8 <= IOU_RESET;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_OVERLAP: ov_q8  <= cfg_data;
        REG_IOU:     iou_q8 <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.count_clr) begin
        count <= '0;
      end else if (cmd.count_inc) begin
        count <= count + 1'b1;
      end
      if (cmd.pend_clr) begin
        pend_valid <= 1'b0;
      end else if (cmd.pend_load) begin
        pend_valid <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_new) begin
      nb_x    <= box_x;
      nb_y    <= box_y;
      nb_w    <= box_w;
      nb_h    <= box_h;
      nb_s    <= score;
      nb_area <= box_w * box_h;
    end
    if (cmd.p_load) begin
      p <= count;
    end else if (cmd.p_dec) begin
      p <= p - 1'b1;
    end
    if (cmd.i_clr) begin
      i <= '0;
    end else if (cmd.i_inc) begin
      i <= i + 1'b1;
    end
    if (cmd.j_load) begin
      j <= AW'(count - 1'b1);
    end else if (cmd.j_dec) begin
      j <= j - 1'b1;
    end
    if (cmd.k_clr) begin
      k <= '0;
    end else if (cmd.k_inc) begin
      k <= k + 1'b1;
    end
    if (cmd.bi_load) begin
      bi <= q;
    end
    if (cmd.pend_load) begin
      pend <= q;
    end
    if (cmd.out_load) begin
      out_x     <= pend[X_LO +: C];
      out_y     <= pend[Y_LO +: C];
      out_w     <= pend[W_LO +: C];
      out_h     <= pend[H_LO +: C];
      out_score <= pend[S_LO +: SCORE_BITS];
      last_out  <= cmd.out_last;
    end
  end

  // overlap test: extents, then products, then union, then threshold product
  always_comb begin
    ax2 = {1'b0, bx} + {1'b0, bw};
    bx2 = {1'b0, qx} + {1'b0, qw};
    ay2 = {1'b0, by} + {1'b0, bh};
    by2 = {1'b0, qy} + {1'b0, qh};
    x1  = (bx > qx) ? {1'b0, bx} : {1'b0, qx};
    y1  = (by > qy) ? {1'b0, by} : {1'b0, qy};
    x2  = (ax2 < bx2) ? ax2 : bx2;
    y2  = (ay2 < by2) ? ay2 : by2;
  end

  always_ff @(posedge clk) begin
    dx      <= (x2 > x1) ? (x2 - x1) : '0;
    dy      <= (y2 > y1) ? (y2 - y1) : '0;
    inter   <= dx * dy;
    prod1   <= ov_q8 * qa;
    un      <= (AB + 1)'(({2'b0, ba} + {2'b0, qa}) - inter);
    contain <= ({inter, 8'b0} > {2'b0, prod1}) && (bs >= qs);
    prod2   <= iou_q8 * un;
  end

  assign sts.full       = (count == CW'(MAX_BOXES));
  assign sts.p_zero     = (p == '0);
  assign sts.area_ge    = (qa >= nb_area);
  assign sts.i_done     = (i >= count);
  assign sts.j_gt_i     = ({1'b0, j} > (AW + 1)'(i));
  assign sts.alive      = alive_q;
  assign sts.contain    = contain;
  assign sts.iou_hit    = (un != '0) && ({inter, 8'b0} > {1'b0, prod2});
  assign sts.score_ge   = (bs >= qs);
  assign sts.k_done     = (k >= count);
  assign sts.pend_valid = pend_valid;
  assign sts.out_busy   = out_valid & ~out_ready;

endmodule

>>> hw/rtl/box_non_max_suppression_core.sv
// Greedy non-maximum suppression over a set of detection boxes.
// Input channel (in_valid/in_ready): one box per request; last_in closes
// the set. Each box is placed in an area-sorted store (largest first),
// shifting smaller entries down one slot each. A box that arrives while
// MAX_BOXES are held is dropped. After the last box, suppression tests
// each kept box against later ones, each pair by one store read, then the
// intersection, product, union and threshold stages in turn; dead entries
// are skipped. Survivors leave on the output channel (out_valid/out_ready)
// in store order, last_out on the final one. An empty result sends nothing.
// in_ready is high only while waiting for a box; a stalled receiver holds
// the output register and the scan waits on it. The last survivor may still
// wait in the output register while the next set starts loading.
// cfg_en/cfg_index/cfg_data write the two Q0.8 thresholds; the user must
// write them only while idle, the block does not enforce it. Reset empties
// the store and restores thresholds 128 and 51; no clearing pass is needed.
module box_non_max_suppression_core #(
  parameter int MAX_BOXES  = bnms_pkg::DEF_MAX_BOXES,
  parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_en,
  input  logic [bnms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bnms_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              box_x,
  input  logic [COORD_BITS-1:0]              box_y,
  input  logic [COORD_BITS-1:0]              box_w,
  input  logic [COORD_BITS-1:0]              box_h,
  input  logic [bnms_pkg::SCORE_BITS-1:0]    score,
  input  logic                               last_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [COORD_BITS-1:0]              out_x,
  output logic [COORD_BITS-1:0]              out_y,
  output logic [COORD_BITS-1:0]              out_w,
  output logic [COORD_BITS-1:0]              out_h,
  output logic [bnms_pkg::SCORE_BITS-1:0]    out_score,
  output logic                               last_out
);
  import bnms_pkg::*;

  cmd_t    cmd;
  status_t sts;

  bnms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .last_in  (last_in),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bnms_dp #(
    .MAX_BOXES  (MAX_BOXES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_x     (box_x),
    .box_y     (box_y),
    .box_w     (box_w),
    .box_h     (box_h),
    .score     (score),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_x     (out_x),
    .out_y     (out_y),
    .out_w     (out_w),
    .out_h     (out_h),
    .out_score (out_score),
    .last_out  (last_out)
  );

endmodule

>>> hw/rtl/bnms_checker.sv
module bnms_checker #(
  parameter int COORD_BITS = bnms_pkg::DEF_COORD_BITS
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            last_in,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [COORD_BITS-1:0]           out_x,
  input logic [bnms_pkg::SCORE_BITS-1:0] out_score,
  input logic                            last_out
);

  // come out of reset waiting for a request with nothing to send
  a_reset_state: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("bad state after reset");

  // closing request starts suppression, so input must stall next cycle
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_in) |=> !in_ready)
    else $error("input accepted during suppression");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_x) && $stable(out_score) && $stable(last_out)))
    else $error("output changed while stalled");

endmodule

bind box_non_max_suppression_core bnms_checker #(.COORD_BITS(COORD_BITS)) u_bnms_checker (.*);

>>> tb/box_survivor_checker.sv
module box_survivor_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_en,
  input  logic [bnms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bnms_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [11:0]                        box_x,
  input  logic [11:0]                        box_y,
  input  logic [11:0]                        box_w,
  input  logic [11:0]                        box_h,
  input  logic [bnms_pkg::SCORE_BITS-1:0]    score,
  input  logic                               last_in,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [11:0]                        out_x,
  input  logic [11:0]                        out_y,
  input  logic [11:0]                        out_w,
  input  logic [11:0]                        out_h,
  input  logic [bnms_pkg::SCORE_BITS-1:0]    out_score,
  input  logic                               last_out,
  output int                                 fails,
  output int                                 pending
);
  import bnms_pkg::*;

  localparam int DEPTH = DEF_MAX_BOXES;

  typedef struct {
    logic [11:0]           x, y, w, h;
    logic [SCORE_BITS-1:0] s;
    logic                  last;
  } box_t;

  box_t                    sorted_boxes[DEPTH];
  int                      held;
  logic [CFG_DATA_BITS-1:0] contain_q8, iou_q8;
  box_t                    expected_survivors[$];

  function automatic longint unsigned area_of(box_t b);
    return longint'(b.w) * longint'(b.h);
  endfunction

  function automatic longint unsigned overlap_area(box_t a, box_t b);
    longint unsigned x1, y1, x2, y2;
    x1 = (a.x > b.x) ? a.x : b.x;
    y1 = (a.y > b.y) ? a.y : b.y;
    x2 = ((a.x + 64'(a.w)) < (b.x + 64'(b.w))) ? a.x + 64'(a.w) : b.x + 64'(b.w);
    y2 = ((a.y + 64'(a.h)) < (b.y + 64'(b.h))) ? a.y + 64'(a.h) : b.y + 64'(b.h);
    if (x2 <= x1 || y2 <= y1) return 0;
    return (x2 - x1) * (y2 - y1);
  endfunction

  task automatic store_box(box_t nb);
    int pos;
    pos = 0;
    if (held >= DEPTH) return;
    while (pos < held && area_of(sorted_boxes[pos]) >= area_of(nb)) pos++;
    for (int k = held; k > pos; k--) sorted_boxes[k] = sorted_boxes[k-1];
    sorted_boxes[pos] = nb;
    held++;
  endtask

  task automatic predict_survivors();
    int keep[$];
    int i, j;
    bit restart;
    box_t bi, bj, r;
    longint unsigned inter, uni;
    for (int k = 0; k < held; k++) keep.insert(keep.size(), k);
    i = 0;
    while (i < keep.size()) begin
      j = keep.size() - 1;
      restart = 0;
      while (j > i) begin
        bi = sorted_boxes[keep[i]];
        bj = sorted_boxes[keep[j]];
        inter = overlap_area(bi, bj);
        uni = area_of(bi) + area_of(bj) - inter;
        if (inter * 256 > contain_q8 * area_of(bj) && bi.s >= bj.s) begin
          keep.delete(j);
          j--;
        end else if (uni != 0 && inter * 256 > iou_q8 * uni) begin
          if (bi.s >= bj.s) begin
            keep.delete(j);
            j--;
          end else begin
            keep.delete(i);
            restart = 1;
            break;
          end
        end else begin
          j--;
        end
      end
      if (!restart) i++;
    end
    foreach (keep[k]) begin
      r = sorted_boxes[keep[k]];
      r.last = (k == keep.size() - 1);
      expected_survivors.insert(expected_survivors.size(), r);
    end
    held = 0;
  endtask

  assign pending = expected_survivors.size();

  always @(posedge clk) begin
    box_t nb, exp_box;
    if (rst) begin
      held = 0;
      contain_q8 = OVERLAP_RESET;
      iou_q8 = IOU_RESET;
      expected_survivors.delete();
      fails = 0;
    end else begin
      if (cfg_en) begin
        if (cfg_index == REG_OVERLAP) contain_q8 = cfg_data;
        else if (cfg_index == REG_IOU) iou_q8 = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_survivors.size() == 0) begin
          $display("%0t: unexpected box x=%0d y=%0d w=%0d h=%0d s=%0d last=%0d", $time,
                   out_x, out_y, out_w, out_h, out_score, last_out);
          fails++;
        end else begin
          exp_box = expected_survivors.pop_front();
          if (out_x !== exp_box.x || out_y !== exp_box.y || out_w !== exp_box.w ||
              out_h !== exp_box.h || out_score !== exp_box.s ||
              last_out !== exp_box.last) begin
            $display("%0t: expected x=%0d y=%0d w=%0d h=%0d s=%0d last=%0d", $time,
                     exp_box.x, exp_box.y, exp_box.w, exp_box.h, exp_box.s, exp_box.last);
            $display("%0t:   actual x=%0d y=%0d w=%0d h=%0d s=%0d last=%0d", $time,
                     out_x, out_y, out_w, out_h, out_score, last_out);
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        nb = '{box_x, box_y, box_w, box_h, score, 1'b0};
        store_box(nb);
        if (last_in) predict_survivors();
      end
    end
  end
endmodule

>>> tb/tb.sv
module tb;
  import bnms_pkg::*;

  logic                      clk, rst;
  logic                      cfg_en;
  logic [CFG_IDX_BITS-1:0]   cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid, in_ready;
  logic [11:0]               box_x, box_y, box_w, box_h;
  logic [SCORE_BITS-1:0]     score;
  logic                      last_in;
  logic                      out_valid, out_ready;
  logic [11:0]               out_x, out_y, out_w, out_h;
  logic [SCORE_BITS-1:0]     out_score;
  logic                      last_out;
  int                        fails, pending;
  int                        send_idle_pct, recv_stall_pct;
  bit                        hold_req;

  box_non_max_suppression_core dut (.*);

  box_survivor_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    out_ready <= 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_box(input logic [11:0] x, y, w, h, input logic [15:0] s,
                          input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1;
    box_x <= x;
    box_y <= y;
    box_w <= w;
    box_h <= h;
    score <= s;
    last_in <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // drain all results, then let the block settle before touching registers
  task automatic drain_and_write(input logic [7:0] contain, iou);
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    cfg_en <= 1;
    cfg_index <= REG_OVERLAP;
    cfg_data <= contain;
    @(posedge clk);
    cfg_index <= REG_IOU;
    cfg_data <= iou;
    @(posedge clk);
    cfg_en <= 0;
  endtask

  // a cluster of overlapping boxes with an occasional box anywhere
  task automatic send_random_set(input int n);
    logic [11:0] bx, by;
    bx = 12'($urandom_range(4095));
    by = 12'($urandom_range(4095));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(9) == 0)
        send_box(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                 16'($urandom_range(65535)), k == n - 1);
      else
        send_box(12'(bx + $urandom_range(15)), 12'(by + $urandom_range(15)),
                 12'(8 + $urandom_range(40)), 12'(8 + $urandom_range(40)),
                 ($urandom_range(3) == 0) ? 16'd1000 : 16'($urandom), k == n - 1);
    end
  endtask

  initial begin
    int sent;
    rst <= 1;
    cfg_en <= 0;
    cfg_index <= REG_OVERLAP;
    cfg_data <= 0;
    in_valid <= 0;
    box_x <= 0;
    box_y <= 0;
    box_w <= 0;
    box_h <= 0;
    score <= 0;
    last_in <= 0;
    hold_req = 0;
    send_idle_pct = 37;
    recv_stall_pct = 66;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes, zero-area boxes, zero union, equal areas and score ties
    send_box(12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF, 0);
    send_box(0, 0, 0, 0, 0, 0);
    send_box(0, 0, 0, 12'd5, 16'd7, 0);
    send_box(12'd10, 12'd10, 12'd20, 12'd20, 16'd100, 0);
    send_box(12'd12, 12'd12, 12'd20, 12'd20, 16'd100, 0);
    send_box(12'd11, 12'd11, 12'd10, 12'd10, 16'd200, 0);
    send_box(12'd14, 12'd14, 12'd20, 12'd20, 16'd300, 0);
    send_box(0, 0, 12'd4095, 12'd4095, 0, 1);
    send_box(12'd2730, 12'd1365, 12'd1, 12'd1, 16'h5555, 1);
    drain_and_write(8'd0, 8'd0);
    send_random_set(6);
    drain_and_write(8'd255, 8'd255);
    send_random_set(6);
    drain_and_write(8'd128, 8'd51);

    // store full: the extra boxes are dropped, the last one still closes the set
    for (int k = 0; k < DEF_MAX_BOXES + 2; k++)
      send_box(12'($urandom_range(300)), 12'($urandom_range(300)),
               12'($urandom_range(60)), 12'($urandom_range(60)), 16'($urandom),
               k == DEF_MAX_BOXES + 1);

    // receiver holds off while sets keep coming
    hold_req = 1;
    send_random_set(5);
    send_random_set(5);
    drain_and_write(8'($urandom), 8'($urandom));

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 66 : 0;
      recv_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < 6; n += sent) begin
        sent = 1 + $urandom_range(7);
        send_random_set(sent);
      end
      drain_and_write(8'($urandom), 8'($urandom));
    end

    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    if (fails == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/bnms_pkg.sv
hw/rtl/bnms_ctrl.sv
hw/rtl/bnms_dp.sv
hw/rtl/box_non_max_suppression_core.sv
hw/rtl/bnms_checker.sv
tb/box_survivor_checker.sv
tb/tb.sv
